// File: sv/tre_pkg.sv
// Shared constants, types and codes for the Thevenin resistance estimator.
// No dependencies; compiled first.
package tre_pkg;

    localparam int FRAC_BITS = 10;
    localparam int VOLT_UNIT = 1000;

    localparam int DATA_W    = 16;
    localparam int RES_W     = 32;
    localparam int OP_W      = 3;

    // divider: dividend is |dv| (17 bits) shifted up by FRAC_BITS
    localparam int DIV_W     = DATA_W + 1 + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int REM_W     = RES_W + 1;

    // serial multiplier: unsigned 16 x signed 16
    localparam int MUL_W     = 2 * DATA_W + 1;
    localparam int MUL_CNT_W = $clog2(DATA_W);

    // readable resistance product: 17-bit magnitude x 16-bit unit
    localparam int RD_W      = 2 * DATA_W + 1;

    localparam int STEP_SHIFT = 5;
    localparam int STEP_MIN   = 25;

    localparam logic signed [RES_W-1:0] DEF_RES =
        RES_W'((123 * (1 << FRAC_BITS)) / 1000);

    typedef enum logic [OP_W-1:0] {
        OP_ADD_POINT = 3'd0,
        OP_UPDATE    = 3'd1,
        OP_COMPUTE   = 3'd2,
        OP_RESTART   = 3'd3,
        OP_INIT      = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_UPD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [RES_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } div_rsp_t;

endpackage

// File: sv/tre_if.sv
// Channel interfaces: input item, result item and configuration write.
// Depends on tre_pkg for field widths.
interface tre_sample_if;
    logic                        valid;
    logic                        ready;
    logic [tre_pkg::OP_W-1:0]    op;
    logic [tre_pkg::DATA_W-1:0]  current_in;
    logic [tre_pkg::DATA_W-1:0]  voltage_in;
    logic [tre_pkg::DATA_W-1:0]  voltage_limit;

    modport source (output valid, op, current_in, voltage_in, voltage_limit, input ready);
    modport sink   (input valid, op, current_in, voltage_in, voltage_limit, output ready);
endinterface

interface tre_result_if;
    logic                              valid;
    logic                              ready;
    logic [tre_pkg::DATA_W-1:0]        current_out;
    logic [tre_pkg::DATA_W-1:0]        open_voltage;
    logic signed [tre_pkg::RES_W-1:0]  resistance_out;
    logic [tre_pkg::DATA_W-1:0]        readable_resistance;
    logic                              point_accepted;
    logic                              divide_error;

    modport source (output valid, current_out, open_voltage, resistance_out,
                    readable_resistance, point_accepted, divide_error, input ready);
    modport sink   (input valid, current_out, open_voltage, resistance_out,
                    readable_resistance, point_accepted, divide_error, output ready);
endinterface

interface tre_cfg_if;
    logic valid;
    logic ready;
    logic charge_mode;

    modport source (output valid, charge_mode, input ready);
    modport sink   (input valid, charge_mode, output ready);
endinterface

// File: sv/tre_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tre_pkg (widths, request/response structs).
module tre_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  tre_pkg::div_req_t req,
    output tre_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [tre_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [tre_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [tre_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [tre_pkg::RES_W-1:0]     dvs_reg, dvs_next;

    logic [tre_pkg::REM_W-1:0]     shifted;
    logic [tre_pkg::REM_W:0]       trial;
    logic                          ge;

    // shift in next dividend bit, trial subtract
    assign shifted = {rem_reg[tre_pkg::REM_W-2:0], quo_reg[tre_pkg::DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = ~trial[tre_pkg::REM_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = tre_pkg::DIV_CNT_W'(tre_pkg::DIV_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[tre_pkg::DIV_W-2:0], ge};
            rem_next = ge ? trial[tre_pkg::REM_W-1:0] : shifted;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tre_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: sv/thevenin_resistance_estimator_top.sv
// Thevenin resistance estimator, top level: op sequencer, model state,
// serial multiplier and result register. Depends on tre_pkg, tre_if.sv, tre_div.
// Path from the accepting edge to result valid: EXEC and FIN for ops that neither
//   multiply nor divide; EXEC, MUL, UPD and FIN for update (16-step shift-add
//   multiply); EXEC, DIV and FIN for a sweep point or a compute current that divides
//   (27-step serial divider); FIN waits while a stalled result holds the register.
// One item at a time, ready again with result valid; the divider sets the worst case.
// Reset (rst_n, async, active low): charge mode, sweep points cleared, open
//   voltage 0, resistance at the charging default, no result pending.
module thevenin_resistance_estimator_top
(
    input  logic                clk,
    input  logic                rst_n,
    tre_sample_if.sink          sample,
    tre_result_if.source        result,
    tre_cfg_if.sink             cfg
);

    localparam int DW = tre_pkg::DATA_W;
    localparam int RW = tre_pkg::RES_W;
    localparam int MW = tre_pkg::MUL_W;
    localparam int FB = tre_pkg::FRAC_BITS;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    tre_pkg::state_t state_reg, state_next;
    logic            charge_mode_reg;

    // model state
    logic [DW-1:0]          first_current_reg, first_current_next;
    logic [DW-1:0]          first_voltage_reg, first_voltage_next;
    logic [DW-1:0]          last_current_reg, last_current_next;
    logic signed [RW-1:0]   resistance_reg, resistance_next;
    logic [DW-1:0]          open_voltage_reg, open_voltage_next;

    // captured item
    tre_pkg::op_t           op_reg;
    logic [DW-1:0]          cur_reg, volt_reg, lim_reg;

    // serial multiplier
    logic signed [MW-1:0]          acc_reg, acc_next;
    logic [DW-1:0]                 mplier_reg, mplier_next;
    logic signed [DW-1:0]          mcand_reg, mcand_next;
    logic [tre_pkg::MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;

    // per-item flags
    logic                   neg_reg, neg_next;
    logic [DW-1:0]          cur_out_reg, cur_out_next;
    logic                   accepted_reg, accepted_next;
    logic                   div_err_reg, div_err_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [DW-1:0]          out_current_reg, out_current_next;
    logic [DW-1:0]          out_open_reg, out_open_next;
    logic signed [RW-1:0]   out_res_reg, out_res_next;
    logic [DW-1:0]          out_read_reg, out_read_next;
    logic                   out_acc_reg, out_acc_next;
    logic                   out_err_reg, out_err_next;

    tre_pkg::div_req_t      div_req;
    tre_pkg::div_rsp_t      div_rsp;

    // ------------------------------------------------------------------
    // Sweep point test
    // ------------------------------------------------------------------
    logic signed [DW:0]     span;
    logic [DW:0]            span_abs;
    logic [DW:0]            step_raw;
    logic [DW:0]            step_eff;
    logic [DW+1:0]          last_plus;
    logic                   cur_gt;
    logic signed [DW:0]     dv_pt;
    logic [DW:0]            dv_pt_abs;
    logic signed [DW:0]     di_pt;
    logic                   di_pos;
    logic                   dir_ok;

    assign span      = $signed({1'b0, last_current_reg}) - $signed({1'b0, first_current_reg});
    assign span_abs  = span[DW] ? (DW+1)'(-span) : (DW+1)'(span);
    assign step_raw  = span_abs >> tre_pkg::STEP_SHIFT;
    assign step_eff  = (step_raw == '0) ? (DW+1)'(tre_pkg::STEP_MIN) : step_raw;
    assign last_plus = (DW+2)'(last_current_reg) + (DW+2)'(step_eff);
    assign cur_gt    = (DW+2)'(cur_reg) > last_plus;

    assign dv_pt     = $signed({1'b0, volt_reg}) - $signed({1'b0, first_voltage_reg});
    assign dv_pt_abs = dv_pt[DW] ? (DW+1)'(-dv_pt) : (DW+1)'(dv_pt);
    assign di_pt     = $signed({1'b0, cur_reg}) - $signed({1'b0, first_current_reg});
    assign di_pos    = ~di_pt[DW] && (di_pt != '0);
    // charging wants the voltage to rise with current, discharging to fall
    assign dir_ok    = charge_mode_reg ? (~dv_pt[DW] && (dv_pt != '0)) : dv_pt[DW];

    // ------------------------------------------------------------------
    // Compute current operands
    // ------------------------------------------------------------------
    logic signed [DW:0]     dv_cc;
    logic [DW:0]            dv_cc_abs;
    logic                   dv_cc_pos;
    logic                   res_zero;
    logic [RW-1:0]          res_abs;
    logic                   same_sign;

    assign dv_cc     = $signed({1'b0, volt_reg}) - $signed({1'b0, open_voltage_reg});
    assign dv_cc_abs = dv_cc[DW] ? (DW+1)'(-dv_cc) : (DW+1)'(dv_cc);
    assign dv_cc_pos = ~dv_cc[DW] && (dv_cc != '0);
    assign res_zero  = (resistance_reg == '0);
    assign res_abs   = resistance_reg[RW-1] ? RW'(-resistance_reg) : RW'(resistance_reg);
    // a negative or zero quotient clips to zero, so only like signs divide
    assign same_sign = (dv_cc != '0) && (dv_cc[DW] == resistance_reg[RW-1]);

    // ------------------------------------------------------------------
    // Resistance clipped to 16 bits, readable form
    // ------------------------------------------------------------------
    logic signed [DW-1:0]         res_clip;
    logic signed [DW:0]           clip_ext;
    logic [DW:0]                  clip_mag;
    logic [tre_pkg::RD_W-1:0]     rd_prod;
    logic [tre_pkg::RD_W-1:0]     rd_shift;
    logic [DW-1:0]                rd_sat;

    always_comb
    begin
        if (resistance_reg > 32'sd32767)
            res_clip = 16'sh7FFF;
        else if (resistance_reg < -32'sd32768)
            res_clip = 16'sh8000;
        else
            res_clip = resistance_reg[DW-1:0];
    end

    assign clip_ext = {res_clip[DW-1], res_clip};
    assign clip_mag = clip_ext[DW] ? (DW+1)'(-clip_ext) : (DW+1)'(clip_ext);
    assign rd_prod  = tre_pkg::RD_W'(clip_mag) * tre_pkg::RD_W'(tre_pkg::VOLT_UNIT);
    assign rd_shift = rd_prod >> FB;
    assign rd_sat   = (rd_shift[tre_pkg::RD_W-1:DW] != '0) ? '1 : rd_shift[DW-1:0];

    // ------------------------------------------------------------------
    // Update op: drop = floor(cur * r / 2^FRAC_BITS)
    // ------------------------------------------------------------------
    logic signed [MW-1:0]   drop;
    logic signed [MW:0]     nv;
    logic [DW-1:0]          nv_sat;
    logic signed [MW-1:0]   mul_addend;

    // arithmetic shift gives the floor for negative products
    assign drop   = acc_reg >>> FB;
    assign nv     = $signed({{(MW+1-DW){1'b0}}, volt_reg}) - $signed({drop[MW-1], drop});
    assign nv_sat = nv[MW] ? '0 : ((nv[MW-1:DW] != '0) ? '1 : nv[DW-1:0]);

    assign mul_addend = mplier_reg[DW-1] ? {{(MW-DW){mcand_reg[DW-1]}}, mcand_reg} : '0;

    // ------------------------------------------------------------------
    // Divider quotient handling
    // ------------------------------------------------------------------
    logic [RW-1:0]          quo_ext;
    logic [DW-1:0]          quo_sat;

    assign quo_ext = RW'(div_rsp.quotient);
    assign quo_sat = (div_rsp.quotient[tre_pkg::DIV_W-1:DW] != '0) ?
                     '1 : div_rsp.quotient[DW-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        first_current_next = first_current_reg;
        first_voltage_next = first_voltage_reg;
        last_current_next  = last_current_reg;
        resistance_next    = resistance_reg;
        open_voltage_next  = open_voltage_reg;
        acc_next           = acc_reg;
        mplier_next        = mplier_reg;
        mcand_next         = mcand_reg;
        mul_cnt_next       = mul_cnt_reg;
        neg_next           = neg_reg;
        cur_out_next       = cur_out_reg;
        accepted_next      = accepted_reg;
        div_err_next       = div_err_reg;
        out_valid_next     = out_valid_reg;
        out_current_next   = out_current_reg;
        out_open_next      = out_open_reg;
        out_res_next       = out_res_reg;
        out_read_next      = out_read_reg;
        out_acc_next       = out_acc_reg;
        out_err_next       = out_err_reg;
        div_req            = '0;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            tre_pkg::ST_IDLE:
            begin
                if (sample.valid)
                    state_next = tre_pkg::ST_EXEC;
            end

            tre_pkg::ST_EXEC:
            begin
                cur_out_next  = '0;
                accepted_next = 1'b0;
                div_err_next  = 1'b0;
                state_next    = tre_pkg::ST_FIN;
                case (op_reg)
                    tre_pkg::OP_ADD_POINT:
                    begin
                        if (volt_reg != '0)
                        begin
                            if (first_current_reg == '0)
                            begin
                                // first point of the sweep
                                first_current_next = cur_reg;
                                first_voltage_next = volt_reg;
                                last_current_next  = cur_reg;
                            end
                            else if (cur_gt && dir_ok && di_pos)
                            begin
                                neg_next         = dv_pt[DW];
                                div_req.start    = 1'b1;
                                div_req.dividend = {dv_pt_abs, {FB{1'b0}}};
                                div_req.divisor  = RW'(di_pt[DW-1:0]);
                                state_next       = tre_pkg::ST_DIV;
                            end
                        end
                    end

                    tre_pkg::OP_UPDATE:
                    begin
                        acc_next     = '0;
                        mplier_next  = cur_reg;
                        mcand_next   = res_clip;
                        mul_cnt_next = '1;
                        state_next   = tre_pkg::ST_MUL;
                    end

                    tre_pkg::OP_COMPUTE:
                    begin
                        if (res_zero)
                        begin
                            div_err_next = 1'b1;
                            cur_out_next = dv_cc_pos ? '1 : '0;
                        end
                        else if (same_sign)
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {dv_cc_abs, {FB{1'b0}}};
                            div_req.divisor  = res_abs;
                            state_next       = tre_pkg::ST_DIV;
                        end
                    end

                    tre_pkg::OP_RESTART:
                    begin
                        first_current_next = '0;
                        first_voltage_next = '0;
                        last_current_next  = '0;
                    end

                    tre_pkg::OP_INIT:
                    begin
                        if (charge_mode_reg)
                            open_voltage_next = (volt_reg < lim_reg) ? volt_reg : lim_reg;
                        else
                            open_voltage_next = (volt_reg > lim_reg) ? volt_reg : lim_reg;
                        resistance_next    = charge_mode_reg ? tre_pkg::DEF_RES
                                                             : -tre_pkg::DEF_RES;
                        first_current_next = '0;
                        first_voltage_next = '0;
                        last_current_next  = '0;
                    end

                    default:
                    begin
                    end
                endcase
            end

            tre_pkg::ST_MUL:
            begin
                // MSB first shift-add
                acc_next     = {acc_reg[MW-2:0], 1'b0} + mul_addend;
                mplier_next  = {mplier_reg[DW-2:0], 1'b0};
                mul_cnt_next = mul_cnt_reg - 1'b1;
                if (mul_cnt_reg == '0)
                    state_next = tre_pkg::ST_UPD;
            end

            tre_pkg::ST_UPD:
            begin
                open_voltage_next = nv_sat;
                state_next        = tre_pkg::ST_FIN;
            end

            tre_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (op_reg == tre_pkg::OP_ADD_POINT)
                    begin
                        resistance_next   = neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
                        last_current_next = cur_reg;
                        accepted_next     = 1'b1;
                    end
                    else
                        cur_out_next = quo_sat;
                    state_next = tre_pkg::ST_FIN;
                end
            end

            tre_pkg::ST_FIN:
            begin
                // wait for a free result register
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_current_next = cur_out_reg;
                    out_open_next    = open_voltage_reg;
                    out_res_next     = resistance_reg;
                    out_read_next    = rd_sat;
                    out_acc_next     = accepted_reg;
                    out_err_next     = div_err_reg;
                    state_next       = tre_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tre_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tre_pkg::ST_IDLE;
            charge_mode_reg   <= 1'b1;
            first_current_reg <= '0;
            first_voltage_reg <= '0;
            last_current_reg  <= '0;
            resistance_reg    <= tre_pkg::DEF_RES;
            open_voltage_reg  <= '0;
            mul_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            if (cfg.valid)
                charge_mode_reg <= cfg.charge_mode;
            first_current_reg <= first_current_next;
            first_voltage_reg <= first_voltage_next;
            last_current_reg  <= last_current_next;
            resistance_reg    <= resistance_next;
            open_voltage_reg  <= open_voltage_next;
            mul_cnt_reg       <= mul_cnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tre_pkg::ST_IDLE && sample.valid)
        begin
            op_reg   <= tre_pkg::op_t'(sample.op);
            cur_reg  <= sample.current_in;
            volt_reg <= sample.voltage_in;
            lim_reg  <= sample.voltage_limit;
        end
        acc_reg          <= acc_next;
        mplier_reg       <= mplier_next;
        mcand_reg        <= mcand_next;
        neg_reg          <= neg_next;
        cur_out_reg      <= cur_out_next;
        accepted_reg     <= accepted_next;
        div_err_reg      <= div_err_next;
        out_current_reg  <= out_current_next;
        out_open_reg     <= out_open_next;
        out_res_reg      <= out_res_next;
        out_read_reg     <= out_read_next;
        out_acc_reg      <= out_acc_next;
        out_err_reg      <= out_err_next;
    end

    // shared divider for sweep slope and target current
    tre_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign sample.ready = (state_reg == tre_pkg::ST_IDLE);
    assign cfg.ready    = 1'b1;

    assign result.valid               = out_valid_reg;
    assign result.current_out         = out_current_reg;
    assign result.open_voltage        = out_open_reg;
    assign result.resistance_out      = out_res_reg;
    assign result.readable_resistance = out_read_reg;
    assign result.point_accepted      = out_acc_reg;
    assign result.divide_error        = out_err_reg;

endmodule

// File: sv/tre_checker.sv
// Port-level checks for the Thevenin resistance estimator, bound to the top.
// Depends on tre_pkg and thevenin_resistance_estimator_top.
module tre_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [tre_pkg::DATA_W-1:0]        res_current,
    input logic signed [tre_pkg::RES_W-1:0]  res_resistance,
    input logic                              res_point_accepted,
    input logic                              res_divide_error
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_resistance) && $stable(res_current))
        else $error("stalled result changed");

    // one item in flight: no acceptance straight after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    // zero resistance saturates the current to one of its ends
    a_div_err_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_divide_error |->
            (res_current == '0 || res_current == '1))
        else $error("divide error without saturated current");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_point_accepted && res_divide_error))
        else $error("point accepted and divide error together");

endmodule

bind thevenin_resistance_estimator_top tre_checker u_tre_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (sample.valid),
    .in_ready           (sample.ready),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .res_current        (result.current_out),
    .res_resistance     (result.resistance_out),
    .res_point_accepted (result.point_accepted),
    .res_divide_error   (result.divide_error)
);
